[rtl/osrb_pkg.sv]
// shared types and constants of the overwrite slot ring buffer
package osrb_pkg;

	localparam int CMD_W      = 2;
	localparam int BYTE_W     = 8;
	localparam int RLEN_W     = 7;
	localparam int FILL_OUT_W = 4;
	localparam int SLOT_OUT_W = 3;
	localparam int THR_W      = 4;

	localparam logic [THR_W-1:0] THR_RESET = 4'd8;

	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = PADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_FULL_THRESHOLD = '0;

	localparam int OUTQ_DEPTH = 3;
	localparam int QCNT_W     = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE  = 2'd0,
		CMD_READ   = 2'd1,
		CMD_STATUS = 2'd2
	} cmd_e;

	typedef struct packed {
		logic [BYTE_W-1:0]     out_byte;
		logic                  out_last;
		logic                  ok;
		logic [FILL_OUT_W-1:0] fill_level;
		logic                  full_flag;
		logic                  empty_flag;
		logic [SLOT_OUT_W-1:0] write_slot;
		logic [SLOT_OUT_W-1:0] read_slot;
	} result_t;

endpackage

[rtl/osrb_req_if.sv]
// request channel: command beats into the ring buffer
interface osrb_req_if import osrb_pkg::*;;
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [BYTE_W-1:0]   data_byte;
	logic                byte_last;
	logic [RLEN_W-1:0]   read_length;

	modport source (output valid, command, data_byte, byte_last, read_length, input ready);
	modport sink (input valid, command, data_byte, byte_last, read_length, output ready);
endinterface

[rtl/osrb_rsp_if.sv]
// response channel: result beats out of the ring buffer
interface osrb_rsp_if import osrb_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [BYTE_W-1:0]     out_byte;
	logic                  out_last;
	logic                  ok;
	logic [FILL_OUT_W-1:0] fill_level;
	logic                  full_flag;
	logic                  empty_flag;
	logic [SLOT_OUT_W-1:0] write_slot;
	logic [SLOT_OUT_W-1:0] read_slot;

	modport source (output valid, out_byte, out_last, ok, fill_level, full_flag, empty_flag,
		write_slot, read_slot, input ready);
	modport sink (input valid, out_byte, out_last, ok, fill_level, full_flag, empty_flag,
		write_slot, read_slot, output ready);
endinterface

[rtl/overwrite_slot_ring_buffer_top.sv]
// top level of the overwrite slot ring buffer
// A ring of SLOT_COUNT slots of SLOT_BYTES bytes held in one synchronous memory. Write beats
// store one byte each and commit the slot on byte_last; a commit into a full ring drops the
// oldest slot. A write, status or rejected command gives one result beat. An accepted read
// gives read_length result beats, one byte per cycle from the memory read port while the result
// queue has room; no new command is taken until its last byte is issued. Results pass through
// the memory stage register and then a three-entry result queue, so commands keep flowing while
// a result waits to be taken. After reset the memory is zeroed by a sweep over all
// SLOT_COUNT * SLOT_BYTES entries (512 at the defaults), during which no command is taken; the
// threshold register can be written at any time.
module overwrite_slot_ring_buffer_top import osrb_pkg::*; #(
	parameter int SLOT_COUNT = 8,
	parameter int SLOT_BYTES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	osrb_req_if.sink           req,
	osrb_rsp_if.source         rsp
);

	localparam int DEPTH  = SLOT_COUNT * SLOT_BYTES;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [THR_W-1:0]  thr;
	logic [QCNT_W-1:0] q_count;
	logic              push;
	result_t           push_data;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [BYTE_W-1:0] mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [BYTE_W-1:0] mem_rdata;
	logic              mem_busy;

	osrb_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.thr     (thr)
	);

	osrb_mem #(
		.SLOT_COUNT (SLOT_COUNT),
		.SLOT_BYTES (SLOT_BYTES)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.re     (mem_re),
		.raddr  (mem_raddr),
		.rdata  (mem_rdata),
		.busy   (mem_busy)
	);

	osrb_ctrl #(
		.SLOT_COUNT (SLOT_COUNT),
		.SLOT_BYTES (SLOT_BYTES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.thr       (thr),
		.q_count   (q_count),
		.push      (push),
		.push_data (push_data),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.mem_busy  (mem_busy)
	);

	osrb_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.count     (q_count),
		.rsp       (rsp)
	);

endmodule

[rtl/osrb_apb.sv]
// apb register block holding the full threshold
module osrb_apb import osrb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [THR_W-1:0]   thr
);

	logic [THR_W-1:0] thr_q;
	logic             sel_thr;

	assign sel_thr = (paddr[PADDR_W-1:2] == REG_FULL_THRESHOLD);
	assign pready  = 1'b1;
	assign prdata  = sel_thr ? PDATA_W'(thr_q) : '0;
	assign thr     = thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (psel && penable && pwrite && pready && sel_thr) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

endmodule

[rtl/osrb_mem.sv]
// slot byte memory with one write and one registered read port, cleared after reset
module osrb_mem import osrb_pkg::*; #(
	parameter  int SLOT_COUNT = 8,
	parameter  int SLOT_BYTES = 64,
	localparam int DEPTH      = SLOT_COUNT * SLOT_BYTES,
	localparam int ADDR_W     = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [BYTE_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [BYTE_W-1:0] rdata,
	output logic              busy
);

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rdata_q;
	logic [ADDR_W-1:0] clr_q;
	logic              busy_q;

	assign rdata = rdata_q;
	assign busy  = busy_q;

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= '0;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// clearing sweep, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == ADDR_W'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/osrb_outq.sv]
// three-entry result queue in front of the response channel
module osrb_outq import osrb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  result_t           push_data,
	output logic [QCNT_W-1:0] count,
	osrb_rsp_if.source        rsp
);

	result_t           q_q [OUTQ_DEPTH];
	logic [QCNT_W-1:0] wr_q;
	logic [QCNT_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              pop;
	result_t           head;

	assign count = cnt_q;
	assign pop   = rsp.valid & rsp.ready;
	assign head  = q_q[rd_q];

	assign rsp.valid      = (cnt_q != '0);
	assign rsp.out_byte   = head.out_byte;
	assign rsp.out_last   = head.out_last;
	assign rsp.ok         = head.ok;
	assign rsp.fill_level = head.fill_level;
	assign rsp.full_flag  = head.full_flag;
	assign rsp.empty_flag = head.empty_flag;
	assign rsp.write_slot = head.write_slot;
	assign rsp.read_slot  = head.read_slot;

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QCNT_W'(OUTQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QCNT_W'(OUTQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/osrb_ctrl.sv]
// pointer and flag state, command decode, read burst sequencer and memory stage
module osrb_ctrl import osrb_pkg::*; #(
	parameter  int SLOT_COUNT = 8,
	parameter  int SLOT_BYTES = 64,
	localparam int DEPTH      = SLOT_COUNT * SLOT_BYTES,
	localparam int ADDR_W     = $clog2(DEPTH),
	localparam int PTR_W      = $clog2(SLOT_COUNT),
	localparam int FILL_W     = $clog2(SLOT_COUNT + 1),
	localparam int OFS_W      = $clog2(SLOT_BYTES + 1),
	localparam int CMP_W      = (FILL_W > THR_W) ? FILL_W : THR_W
) (
	input  logic              clk,
	input  logic              arst_n,
	osrb_req_if.sink          req,
	input  logic [THR_W-1:0]  thr,
	input  logic [QCNT_W-1:0] q_count,
	output logic              push,
	output result_t           push_data,
	output logic              mem_we,
	output logic [ADDR_W-1:0] mem_waddr,
	output logic [BYTE_W-1:0] mem_wdata,
	output logic              mem_re,
	output logic [ADDR_W-1:0] mem_raddr,
	input  logic [BYTE_W-1:0] mem_rdata,
	input  logic              mem_busy
);

	logic [PTR_W-1:0]  wptr_q, wptr_n, rptr_q, rptr_n, wnext;
	logic [FILL_W-1:0] fill_q, fill_n;
	logic              full_q, full_n, empty_q, empty_n;
	logic [OFS_W-1:0]  ofs_q, ofs_n;
	logic              overrun_q, overrun_n, ov;
	logic              burst_q, burst_n;
	logic [RLEN_W-1:0] left_q, left_n;
	logic [ADDR_W-1:0] baddr_q, baddr_n;
	logic              room, in_fire, burst_fire, issue;
	logic              ok, last, is_data;
	logic              s1_valid_q, data_s1;
	result_t           res_s1;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(SLOT_COUNT - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [ADDR_W-1:0] slot_base(input logic [PTR_W-1:0] p);
		slot_base = ADDR_W'(ADDR_W'(p) * SLOT_BYTES);
	endfunction

	// a new beat may start only if the queue can take it and the one in flight
	assign room       = ({1'b0, q_count} + {{QCNT_W{1'b0}}, s1_valid_q}) < (QCNT_W + 1)'(OUTQ_DEPTH);
	assign req.ready  = room & ~burst_q & ~mem_busy;
	assign in_fire    = req.valid & req.ready;
	assign burst_fire = burst_q & room;
	assign issue      = in_fire | burst_fire;
	assign mem_wdata  = req.data_byte;
	assign wnext      = next_ptr(wptr_q);

	always_comb begin
		wptr_n    = wptr_q;
		rptr_n    = rptr_q;
		fill_n    = fill_q;
		full_n    = full_q;
		empty_n   = empty_q;
		ofs_n     = ofs_q;
		overrun_n = overrun_q;
		burst_n   = burst_q;
		left_n    = left_q;
		baddr_n   = baddr_q;
		ov        = overrun_q;
		mem_we    = 1'b0;
		mem_waddr = slot_base(wptr_q) + ADDR_W'(ofs_q);
		mem_re    = 1'b0;
		mem_raddr = baddr_q;
		ok        = 1'b1;
		last      = 1'b1;
		is_data   = 1'b0;
		if (burst_fire) begin
			mem_re  = 1'b1;
			is_data = 1'b1;
			last    = (left_q == RLEN_W'(1));
			left_n  = left_q - 1'b1;
			baddr_n = baddr_q + 1'b1;
			if (left_q == RLEN_W'(1)) begin
				burst_n = 1'b0;
			end
		end else if (in_fire) begin
			case (req.command)
				CMD_WRITE: begin
					if (ofs_q < OFS_W'(SLOT_BYTES)) begin
						mem_we = 1'b1;
						ofs_n  = ofs_q + 1'b1;
					end else begin
						ov = 1'b1;
					end
					overrun_n = ov;
					ok        = ~ov;
					if (req.byte_last) begin
						if (!ov) begin
							if (fill_q < FILL_W'(SLOT_COUNT)) begin
								fill_n = fill_q + 1'b1;
							end else begin
								rptr_n = wnext;
							end
							wptr_n  = wnext;
							full_n  = (CMP_W'(fill_n) >= CMP_W'(thr));
							empty_n = 1'b0;
						end
						ofs_n     = '0;
						overrun_n = 1'b0;
					end
				end
				CMD_READ: begin
					if (req.read_length == '0 || req.read_length > RLEN_W'(SLOT_BYTES) ||
						fill_q == '0) begin
						ok = 1'b0;
					end else begin
						rptr_n    = next_ptr(rptr_q);
						fill_n    = fill_q - 1'b1;
						full_n    = (CMP_W'(fill_n) >= CMP_W'(thr));
						empty_n   = (fill_n == '0);
						mem_re    = 1'b1;
						mem_raddr = slot_base(rptr_q);
						is_data   = 1'b1;
						last      = (req.read_length == RLEN_W'(1));
						if (req.read_length != RLEN_W'(1)) begin
							burst_n = 1'b1;
							left_n  = req.read_length - 1'b1;
							baddr_n = slot_base(rptr_q) + 1'b1;
						end
					end
				end
				CMD_STATUS: begin
					ok = 1'b1;
				end
				default: begin
					ok = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q     <= '0;
			rptr_q     <= '0;
			fill_q     <= '0;
			full_q     <= 1'b0;
			empty_q    <= 1'b1;
			ofs_q      <= '0;
			overrun_q  <= 1'b0;
			burst_q    <= 1'b0;
			left_q     <= '0;
			baddr_q    <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			wptr_q     <= wptr_n;
			rptr_q     <= rptr_n;
			fill_q     <= fill_n;
			full_q     <= full_n;
			empty_q    <= empty_n;
			ofs_q      <= ofs_n;
			overrun_q  <= overrun_n;
			burst_q    <= burst_n;
			left_q     <= left_n;
			baddr_q    <= baddr_n;
			s1_valid_q <= issue;
		end
	end

	// memory stage: status after the beat, byte joined when the read data lands
	always_ff @(posedge clk) begin
		if (issue) begin
			data_s1           <= is_data;
			res_s1.out_byte   <= '0;
			res_s1.out_last   <= last;
			res_s1.ok         <= ok;
			res_s1.fill_level <= FILL_OUT_W'(fill_n);
			res_s1.full_flag  <= full_n;
			res_s1.empty_flag <= empty_n;
			res_s1.write_slot <= SLOT_OUT_W'(wptr_n);
			res_s1.read_slot  <= SLOT_OUT_W'(rptr_n);
		end
	end

	always_comb begin
		push_data = res_s1;
		if (data_s1) begin
			push_data.out_byte = mem_rdata;
		end
	end

	assign push = s1_valid_q;

endmodule

[tb/sv/tb_overwrite_slot_ring_buffer_top.sv]
// self-checking testbench of the overwrite slot ring buffer: directed script, random traffic
module tb_overwrite_slot_ring_buffer_top import osrb_pkg::*;;

	localparam int SLOT_COUNT  = 8;
	localparam int SLOT_BYTES  = 64;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int TAIL_CYCLES = 20;
	localparam int SCRIPT_ROWS = 26;

	localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
	localparam logic [REG_IDX_W-1:0] REG_SPARE  = 1'b1;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [BYTE_W-1:0] data_byte;
		logic              byte_last;
		logic [RLEN_W-1:0] read_length;
	} cmd_beat_t;

	typedef struct packed {
		cmd_beat_t  beat;
		logic [6:0] copies;
		logic       fixed;
		result_t    want;
	} script_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	osrb_req_if req_ch();
	osrb_rsp_if rsp_ch();

	overwrite_slot_ring_buffer_top #(
		.SLOT_COUNT(SLOT_COUNT),
		.SLOT_BYTES(SLOT_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #5 clk = ~clk;

	// ring state as the block should hold it
	logic [BYTE_W-1:0]     ring_mem [SLOT_COUNT*SLOT_BYTES];
	logic [SLOT_OUT_W-1:0] wr_slot;
	logic [SLOT_OUT_W-1:0] rd_slot;
	logic [FILL_OUT_W-1:0] fill_cnt;
	logic                  full_mark;
	logic                  empty_mark;
	logic [RLEN_W-1:0]     wr_offset;
	logic                  overrun;
	logic [THR_W-1:0]      threshold;

	result_t pending_beats[$];

	int  mismatch_count = 0;
	int  cycle_count = 0;
	int  beats_sent = 0;
	int  beats_checked = 0;
	int  commits = 0;
	int  overwrites = 0;
	int  rejects = 0;
	int  thr_settings = 0;
	bit  no_idle = 1'b0;
	bit  req_calm = 1'b0;
	bit  rsp_calm = 1'b0;
	int  stall_left = 0;

	script_row_t script [SCRIPT_ROWS] = '{
		'{'{CMD_STATUS, 8'h00, 1'b0, 7'd0},   7'd1,  1'b1, '{8'h00, 1'b1, 1'b1, 4'd0, 1'b0, 1'b1, 3'd0, 3'd0}},
		'{'{CMD_READ,   8'h00, 1'b0, 7'd5},   7'd1,  1'b1, '{8'h00, 1'b1, 1'b0, 4'd0, 1'b0, 1'b1, 3'd0, 3'd0}},
		'{'{CMD_UNUSED, 8'hff, 1'b1, 7'd127}, 7'd1,  1'b1, '{8'h00, 1'b1, 1'b0, 4'd0, 1'b0, 1'b1, 3'd0, 3'd0}},
		'{'{CMD_READ,   8'h00, 1'b0, 7'd0},   7'd1,  1'b1, '{8'h00, 1'b1, 1'b0, 4'd0, 1'b0, 1'b1, 3'd0, 3'd0}},
		'{'{CMD_WRITE,  8'h00, 1'b0, 7'd0},   7'd1,  1'b1, '{8'h00, 1'b1, 1'b1, 4'd0, 1'b0, 1'b1, 3'd0, 3'd0}},
		'{'{CMD_WRITE,  8'hff, 1'b1, 7'd0},   7'd1,  1'b1, '{8'h00, 1'b1, 1'b1, 4'd1, 1'b0, 1'b0, 3'd1, 3'd0}},
		'{'{CMD_READ,   8'h00, 1'b0, 7'd65},  7'd1,  1'b1, '{8'h00, 1'b1, 1'b0, 4'd1, 1'b0, 1'b0, 3'd1, 3'd0}},
		'{'{CMD_READ,   8'h00, 1'b0, 7'd127}, 7'd1,  1'b1, '{8'h00, 1'b1, 1'b0, 4'd1, 1'b0, 1'b0, 3'd1, 3'd0}},
		'{'{CMD_STATUS, 8'hff, 1'b1, 7'd64},  7'd1,  1'b1, '{8'h00, 1'b1, 1'b1, 4'd1, 1'b0, 1'b0, 3'd1, 3'd0}},
		'{'{CMD_READ,   8'h00, 1'b0, 7'd2},   7'd1,  1'b0, '0},
		'{'{CMD_READ,   8'h00, 1'b0, 7'd64},  7'd1,  1'b1, '{8'h00, 1'b1, 1'b0, 4'd0, 1'b0, 1'b1, 3'd1, 3'd1}},
		'{'{CMD_WRITE,  8'ha5, 1'b0, 7'd0},   7'd64, 1'b0, '0},
		'{'{CMD_WRITE,  8'h5a, 1'b1, 7'd0},   7'd1,  1'b1, '{8'h00, 1'b1, 1'b0, 4'd0, 1'b0, 1'b1, 3'd1, 3'd1}},
		'{'{CMD_WRITE,  8'h3c, 1'b1, 7'd0},   7'd1,  1'b0, '0},
		'{'{CMD_WRITE,  8'hc3, 1'b0, 7'd0},   7'd63, 1'b0, '0},
		'{'{CMD_WRITE,  8'h99, 1'b1, 7'd0},   7'd1,  1'b0, '0},
		'{'{CMD_WRITE,  8'h7e, 1'b0, 7'd0},   7'd64, 1'b0, '0},
		'{'{CMD_WRITE,  8'h81, 1'b0, 7'd0},   7'd1,  1'b0, '0},
		'{'{CMD_WRITE,  8'h42, 1'b0, 7'd0},   7'd1,  1'b0, '0},
		'{'{CMD_WRITE,  8'h24, 1'b1, 7'd0},   7'd1,  1'b0, '0},
		'{'{CMD_READ,   8'h00, 1'b0, 7'd64},  7'd1,  1'b0, '0},
		'{'{CMD_WRITE,  8'h11, 1'b1, 7'd0},   7'd9,  1'b0, '0},
		'{'{CMD_STATUS, 8'h00, 1'b0, 7'd0},   7'd1,  1'b0, '0},
		'{'{CMD_READ,   8'h00, 1'b0, 7'd1},   7'd3,  1'b0, '0},
		'{'{CMD_READ,   8'h00, 1'b0, 7'd64},  7'd1,  1'b0, '0},
		'{'{CMD_READ,   8'h00, 1'b0, 7'd64},  7'd6,  1'b0, '0}
	};

	function automatic string beat_text(input result_t r);
		return $sformatf("byte=%02h last=%0b ok=%0b fill=%0d full=%0b empty=%0b wr=%0d rd=%0d",
			r.out_byte, r.out_last, r.ok, r.fill_level, r.full_flag, r.empty_flag,
			r.write_slot, r.read_slot);
	endfunction

	function automatic logic [SLOT_OUT_W-1:0] slot_after(input logic [SLOT_OUT_W-1:0] s);
		return (s == SLOT_OUT_W'(SLOT_COUNT - 1)) ? '0 : s + 1'b1;
	endfunction

	task automatic push_beat(input logic [BYTE_W-1:0] b, input logic last, input logic ok);
		result_t r;
		r = '{b, last, ok, fill_cnt, full_mark, empty_mark, wr_slot, rd_slot};
		pending_beats.push_back(r);
	endtask

	task automatic ring_reset();
		foreach (ring_mem[i])
			ring_mem[i] = '0;
		wr_slot    = '0;
		rd_slot    = '0;
		fill_cnt   = '0;
		full_mark  = 1'b0;
		empty_mark = 1'b1;
		wr_offset  = '0;
		overrun    = 1'b0;
		threshold  = THR_RESET;
	endtask

	// expected result beats of one accepted command
	task automatic ring_update(input cmd_beat_t it);
		logic                  ok;
		logic [SLOT_OUT_W-1:0] nxt;
		int                    base;
		case (it.command)
			CMD_WRITE: begin
				ok = 1'b1;
				if (wr_offset < SLOT_BYTES) begin
					ring_mem[wr_slot*SLOT_BYTES + wr_offset] = it.data_byte;
					wr_offset++;
				end else begin
					overrun = 1'b1;
				end
				if (overrun)
					ok = 1'b0;
				if (it.byte_last) begin
					if (!overrun) begin
						nxt = slot_after(wr_slot);
						if (fill_cnt < SLOT_COUNT) begin
							fill_cnt++;
						end else begin
							rd_slot = nxt;
							overwrites++;
						end
						wr_slot    = nxt;
						full_mark  = (fill_cnt >= threshold);
						empty_mark = 1'b0;
						commits++;
					end
					wr_offset = '0;
					overrun   = 1'b0;
				end
				if (!ok)
					rejects++;
				push_beat('0, 1'b1, ok);
			end
			CMD_READ: begin
				if (it.read_length == 0 || it.read_length > SLOT_BYTES || fill_cnt == 0) begin
					rejects++;
					push_beat('0, 1'b1, 1'b0);
				end else begin
					base       = rd_slot * SLOT_BYTES;
					rd_slot    = slot_after(rd_slot);
					fill_cnt--;
					full_mark  = (fill_cnt >= threshold);
					empty_mark = (fill_cnt == 0);
					for (int i = 0; i < it.read_length; i++)
						push_beat(ring_mem[base + i], i + 1 == it.read_length, 1'b1);
				end
			end
			default: begin
				if (it.command != CMD_STATUS)
					rejects++;
				push_beat('0, 1'b1, it.command == CMD_STATUS);
			end
		endcase
	endtask

	task automatic send_beat(input cmd_beat_t b, input logic fixed, input result_t want);
		req_ch.valid       <= 1'b1;
		req_ch.command     <= b.command;
		req_ch.data_byte   <= b.data_byte;
		req_ch.byte_last   <= b.byte_last;
		req_ch.read_length <= b.read_length;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		ring_update(b);
		if (fixed) begin
			void'(pending_beats.pop_back());
			pending_beats.push_back(want);
		end
		beats_sent++;
		if ($urandom_range(0, 39) == 0)
			req_calm = !req_calm;
		if (!no_idle && !req_calm && $urandom_range(0, 7) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// stop sending and let every expected beat come back
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_threshold_read();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {REG_FULL_THRESHOLD, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (pready !== 1'b1)
			@(negedge clk);
		if (prdata[THR_W-1:0] !== threshold) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("threshold read mismatch: expected %0d actual %0d",
					threshold, prdata[THR_W-1:0]);
		end
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_threshold(input logic [THR_W-1:0] value);
		logic [PDATA_W-1:0] upper;
		upper = ($urandom_range(0, 1) != 0) ? PDATA_W'($urandom) : '0;
		apb_write(REG_FULL_THRESHOLD, {upper[PDATA_W-1:THR_W], value});
		threshold = value;
		thr_settings++;
		check_threshold_read();
	endtask

	task automatic run_traffic(input int n_items, input int write_pct);
		int        sent;
		int        pick;
		int        len;
		bit        broken;
		cmd_beat_t b;
		sent = 0;
		while (sent < n_items) begin
			pick          = $urandom_range(0, 99);
			b.data_byte   = BYTE_W'($urandom_range(0, 255));
			b.byte_last   = 1'($urandom_range(0, 1));
			b.read_length = RLEN_W'($urandom_range(0, 127));
			if (pick < write_pct) begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					len = $urandom_range(60, 64);
				else if (pick == 1)
					len = $urandom_range(65, 68);
				else
					len = $urandom_range(1, 8);
				broken = ($urandom_range(0, 14) == 0);
				for (int k = 0; k < len; k++) begin
					b.command   = CMD_WRITE;
					b.data_byte = BYTE_W'($urandom_range(0, 255));
					b.byte_last = (k == len - 1) && !broken;
					send_beat(b, 1'b0, '0);
					sent++;
				end
			end else if (pick < write_pct + (100 - write_pct) * 3 / 4) begin
				b.command = CMD_READ;
				pick      = $urandom_range(0, 99);
				if (pick < 80)
					b.read_length = RLEN_W'($urandom_range(1, 12));
				else if (pick < 90)
					b.read_length = RLEN_W'($urandom_range(60, 64));
				else if (pick < 95)
					b.read_length = '0;
				else
					b.read_length = RLEN_W'($urandom_range(65, 127));
				send_beat(b, 1'b0, '0);
				sent++;
			end else begin
				b.command = ($urandom_range(0, 4) == 0) ? CMD_UNUSED : CMD_STATUS;
				send_beat(b, 1'b0, '0);
				sent++;
			end
		end
	endtask

	// result side: check each beat, stall in random bursts
	initial begin
		result_t got;
		result_t want;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got = '{rsp_ch.out_byte, rsp_ch.out_last, rsp_ch.ok, rsp_ch.fill_level,
					rsp_ch.full_flag, rsp_ch.empty_flag, rsp_ch.write_slot, rsp_ch.read_slot};
				if (pending_beats.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result beat: %s", beat_text(got));
				end else begin
					want = pending_beats.pop_front();
					beats_checked++;
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("result mismatch at beat %0d", beats_checked);
							$display("  expected %s", beat_text(want));
							$display("  actual   %s", beat_text(got));
						end
					end
				end
			end
			if ($urandom_range(0, 39) == 0)
				rsp_calm = !rsp_calm;
			if (stall_left != 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!no_idle && !rsp_calm && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still expected",
				cycle_count, pending_beats.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n             <= 1'b0;
		psel               <= 1'b0;
		penable            <= 1'b0;
		pwrite             <= 1'b0;
		paddr              <= '0;
		pwdata             <= '0;
		req_ch.valid       <= 1'b0;
		req_ch.command     <= '0;
		req_ch.data_byte   <= '0;
		req_ch.byte_last   <= 1'b0;
		req_ch.read_length <= '0;
		ring_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_threshold_read();

		foreach (script[r])
			for (int c = 0; c < script[r].copies; c++)
				send_beat(script[r].beat, script[r].fixed, script[r].want);

		drain();
		set_threshold(4'd0);
		run_traffic(25, 55);

		drain();
		set_threshold(4'd15);
		run_traffic(25, 70);

		drain();
		apb_write(REG_SPARE, $urandom);
		check_threshold_read();
		set_threshold(4'd1);
		run_traffic(25, 40);

		drain();
		set_threshold(THR_W'($urandom_range(2, 7)));
		run_traffic(25, 65);

		drain();
		set_threshold(4'd8);
		no_idle = 1'b1;
		run_traffic(25, 60);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d command beats over %0d threshold settings, checked %0d result beats",
			beats_sent, thr_settings, beats_checked);
		$display("%0d slot commits, %0d overwrote the oldest slot, %0d rejected commands",
			commits, overwrites, rejects);
		if (mismatch_count == 0 && pending_beats.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/osrb_pkg.sv
rtl/osrb_req_if.sv
rtl/osrb_rsp_if.sv
rtl/osrb_apb.sv
rtl/osrb_mem.sv
rtl/osrb_outq.sv
rtl/osrb_ctrl.sv
rtl/overwrite_slot_ring_buffer_top.sv
tb/sv/tb_overwrite_slot_ring_buffer_top.sv
